// ===== sv/nwa_pkg.sv =====
package nwa_pkg;

	localparam int STATE_W = 6;
	localparam int SYMBOL_W = 8;
	localparam int SLOT_W = 8;
	localparam int TC_W = 9;
	localparam int MASK_W = 64;
	localparam int CFG_W = 64;
	localparam int NUM_SYMBOLS = 1 << SYMBOL_W;

	localparam int DEF_NUM_STATES = 64;
	localparam int DEF_MAX_TRANSITIONS = 256;

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

	// input modes
	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_ALPHA = 2'd1;
	localparam logic [1:0] MODE_SYMBOL = 2'd2;
	localparam logic [1:0] MODE_QUERY = 2'd3;

	// result causes
	localparam logic [1:0] CAUSE_ACCEPT = 2'd0;
	localparam logic [1:0] CAUSE_NOT_FINAL = 2'd1;
	localparam logic [1:0] CAUSE_EMPTY = 2'd2;
	localparam logic [1:0] CAUSE_FOREIGN = 2'd3;

	// configuration register indexes
	localparam logic [0:0] REG_FINAL_MASK = 1'd0;
	localparam logic [0:0] REG_TRANS_COUNT = 1'd1;

	typedef struct packed {
		logic [1:0]          mode;
		logic [SLOT_W-1:0]   slot;
		logic [STATE_W-1:0]  from_state;
		logic [STATE_W-1:0]  to_state;
		logic [SYMBOL_W-1:0] symbol;
		logic                last;
	} nwa_item_t;

	typedef struct packed {
		logic       accepted;
		logic [1:0] cause;
	} nwa_result_t;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_SYMBOL,
		OP_QUERY
	} nwa_kind_t;

	typedef struct packed {
		nwa_kind_t           kind;
		logic [SLOT_W-1:0]   slot;
		logic [STATE_W-1:0]  from_state;
		logic [STATE_W-1:0]  to_state;
		logic [SYMBOL_W-1:0] symbol;
		logic                last;
		logic                allowed;
	} nwa_op_t;

	typedef struct packed {
		logic [STATE_W-1:0]  src;
		logic [STATE_W-1:0]  dst;
		logic [SYMBOL_W-1:0] label;
	} nwa_edge_t;

	typedef struct packed {
		logic    valid;
		logic    full;
		nwa_op_t head;
	} nwa_queue_status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_REPORT
	} nwa_state_t;

endpackage

// ===== sv/nwa_front.sv =====
module nwa_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  nwa_pkg::nwa_item_t item,
	output logic              item_stall,
	input  logic              queue_full,
	output logic              push,
	output nwa_pkg::nwa_op_t  push_op
);
	import nwa_pkg::*;

	// alphabet bitmap, cleared at reset
	logic [NUM_SYMBOLS-1:0] allowed_q;
	logic                   accept;

	always_comb begin
		item_stall = queue_full;
		accept = item_valid && !queue_full;
		push_op.slot = item.slot;
		push_op.from_state = item.from_state;
		push_op.to_state = item.to_state;
		push_op.symbol = item.symbol;
		push_op.last = item.last;
		push_op.allowed = allowed_q[item.symbol];
		push_op.kind = OP_WRITE;
		push = 1'b0;
		unique case (item.mode)
			MODE_WRITE: begin
				push_op.kind = OP_WRITE;
				push = accept;
			end
			MODE_SYMBOL: begin
				push_op.kind = OP_SYMBOL;
				push = accept;
			end
			MODE_QUERY: begin
				push_op.kind = OP_QUERY;
				push = accept;
			end
			MODE_ALPHA: begin
				push = 1'b0;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allowed_q <= '0;
		end else if (accept && item.mode == MODE_ALPHA) begin
			allowed_q[item.symbol] <= 1'b1;
		end
	end

endmodule

// ===== sv/nwa_queue.sv =====
module nwa_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  nwa_pkg::nwa_op_t          push_op,
	input  logic                      pop,
	output nwa_pkg::nwa_queue_status_t status
);
	import nwa_pkg::*;

	nwa_op_t              entry_q [FIFO_DEPTH];
	logic [FIFO_PW-1:0]   wr_ptr_q;
	logic [FIFO_PW-1:0]   rd_ptr_q;
	logic [FIFO_CW-1:0]   count_q;

	always_comb begin
		status.valid = (count_q != '0);
		status.full = (count_q == FIFO_CW'(FIFO_DEPTH));
		status.head = entry_q[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/nwa_back.sv =====
module nwa_back #(
	parameter int NUM_STATES = nwa_pkg::DEF_NUM_STATES,
	parameter int MAX_TRANSITIONS = nwa_pkg::DEF_MAX_TRANSITIONS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  nwa_pkg::nwa_queue_status_t queue,
	output logic                       pop,
	input  logic [NUM_STATES-1:0]      finals,
	input  logic [nwa_pkg::TC_W-1:0]   trans_count,
	output logic                       result_valid,
	output nwa_pkg::nwa_result_t       result,
	input  logic                       result_stall
);
	import nwa_pkg::*;

	localparam int AW = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
	localparam int NW = ($clog2(MAX_TRANSITIONS + 1) > TC_W) ? $clog2(MAX_TRANSITIONS + 1) : TC_W;
	localparam int SB = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;

	nwa_edge_t             table_mem [MAX_TRANSITIONS];
	nwa_edge_t             rd_edge_s1;
	logic                  rd_v_s1;

	nwa_state_t            state_q;
	nwa_state_t            state_d;
	nwa_op_t               cur_q;
	logic [NUM_STATES-1:0] active_q;
	logic [NUM_STATES-1:0] acc_q;
	logic                  foreign_q;
	logic [NW-1:0]         rd_idx_q;
	logic [NW-1:0]         limit;
	logic                  result_valid_q;
	nwa_result_t           result_q;

	logic                  issue;
	logic                  scan_done;
	logic                  emit;
	logic                  start_scan;
	logic                  mem_we;
	logic                  src_hit;
	logic                  dst_ok;
	logic [1:0]            word_cause;

	assign limit = (NW'(trans_count) > NW'(MAX_TRANSITIONS)) ? NW'(MAX_TRANSITIONS)
		: NW'(trans_count);
	assign result_valid = result_valid_q;
	assign result = result_q;

	always_comb begin
		src_hit = (32'(rd_edge_s1.src) < NUM_STATES) && active_q[SB'(rd_edge_s1.src)];
		dst_ok = (32'(rd_edge_s1.dst) < NUM_STATES);
	end

	always_comb begin
		if (foreign_q) begin
			word_cause = CAUSE_FOREIGN;
		end else if (active_q == '0) begin
			word_cause = CAUSE_EMPTY;
		end else if ((active_q & finals) != '0) begin
			word_cause = CAUSE_ACCEPT;
		end else begin
			word_cause = CAUSE_NOT_FINAL;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (queue.valid) begin
					unique case (queue.head.kind)
						OP_WRITE: state_d = ST_IDLE;
						OP_QUERY: state_d = ST_REPORT;
						OP_SYMBOL: begin
							if (queue.head.allowed && !foreign_q) begin
								state_d = ST_SCAN;
							end else if (queue.head.last) begin
								state_d = ST_REPORT;
							end
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				if (rd_idx_q == limit && !rd_v_s1) begin
					state_d = cur_q.last ? ST_REPORT : ST_IDLE;
				end
			end
			ST_REPORT: begin
				if (!result_valid_q || !result_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		pop = 1'b0;
		issue = 1'b0;
		scan_done = 1'b0;
		emit = 1'b0;
		start_scan = 1'b0;
		mem_we = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				pop = queue.valid;
				mem_we = queue.valid && queue.head.kind == OP_WRITE
					&& (32'(queue.head.slot) < MAX_TRANSITIONS);
				start_scan = queue.valid && queue.head.kind == OP_SYMBOL
					&& queue.head.allowed && !foreign_q;
			end
			ST_SCAN: begin
				issue = (rd_idx_q != limit);
				scan_done = (rd_idx_q == limit) && !rd_v_s1;
			end
			ST_REPORT: begin
				emit = !result_valid_q || !result_stall;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	// transition table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			table_mem[AW'(queue.head.slot)] <= '{src: queue.head.from_state,
				dst: queue.head.to_state, label: queue.head.symbol};
		end
		rd_edge_s1 <= table_mem[rd_idx_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= queue.head;
		end
		if (start_scan) begin
			acc_q <= '0;
		end else if (rd_v_s1 && rd_edge_s1.label == cur_q.symbol && src_hit && dst_ok) begin
			acc_q[SB'(rd_edge_s1.dst)] <= 1'b1;
		end
		if (emit) begin
			if (cur_q.kind == OP_QUERY) begin
				result_q.accepted <= finals[0];
				result_q.cause <= finals[0] ? CAUSE_ACCEPT : CAUSE_NOT_FINAL;
			end else begin
				result_q.accepted <= (word_cause == CAUSE_ACCEPT);
				result_q.cause <= word_cause;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			active_q <= NUM_STATES'(1);
			foreign_q <= 1'b0;
			rd_idx_q <= '0;
			rd_v_s1 <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= issue;
			if (start_scan) begin
				rd_idx_q <= '0;
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (pop && queue.head.kind == OP_SYMBOL && !queue.head.allowed) begin
				foreign_q <= 1'b1;
			end
			if (scan_done) begin
				active_q <= acc_q;
			end
			if (emit && cur_q.kind == OP_SYMBOL) begin
				active_q <= NUM_STATES'(1);
				foreign_q <= 1'b0;
			end
			if (emit) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/nfa_word_acceptor_unit.sv =====
// nfa word acceptor: one word in, at most one result word out
// scan: a scanned word symbol reads min(transition_count, MAX_TRANSITIONS) table entries
// in the back end (none at a zero count) through the single read port of the transition table;
// the last symbol of a word then passes through the report state; writes, queries and skipped symbols do not scan
// result: registered; under result stall the held result stays and the next one waits
// reset: active set is state 0, alphabet and configuration registers cleared, table undefined until written
module nfa_word_acceptor_unit #(
	parameter int NUM_STATES = nwa_pkg::DEF_NUM_STATES,
	parameter int MAX_TRANSITIONS = nwa_pkg::DEF_MAX_TRANSITIONS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_stall,
	input  nwa_pkg::nwa_item_t        item,
	output logic                      result_valid,
	input  logic                      result_stall,
	output nwa_pkg::nwa_result_t      result,
	input  logic                      cfg_we,
	input  logic [0:0]                cfg_index,
	input  logic [nwa_pkg::CFG_W-1:0] cfg_data
);
	import nwa_pkg::*;

	// configuration registers; mask bits above the state count are dropped here
	logic [NUM_STATES-1:0] final_mask_q;
	logic [TC_W-1:0]       trans_count_q;

	// front to queue, queue to back
	logic                  push;
	nwa_op_t               push_op;
	logic                  pop;
	nwa_queue_status_t     queue_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			final_mask_q <= '0;
			trans_count_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FINAL_MASK: final_mask_q <= cfg_data[NUM_STATES-1:0];
				REG_TRANS_COUNT: trans_count_q <= cfg_data[TC_W-1:0];
				default: final_mask_q <= final_mask_q;
			endcase
		end
	end

	// front: takes every word, keeps the alphabet, tags symbols as allowed or foreign
	// alphabet words end here, all others go to the queue in order
	nwa_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_stall (item_stall),
		.queue_full (queue_status.full),
		.push       (push),
		.push_op    (push_op)
	);

	// short queue so the front keeps taking words while the back scans
	nwa_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.push_op(push_op),
		.pop    (pop),
		.status (queue_status)
	);

	// back: owns the transition table and the active set, scans one edge per cycle,
	// and holds the result register toward the output side
	nwa_back #(
		.NUM_STATES      (NUM_STATES),
		.MAX_TRANSITIONS (MAX_TRANSITIONS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.queue        (queue_status),
		.pop          (pop),
		.finals       (final_mask_q),
		.trans_count  (trans_count_q),
		.result_valid (result_valid),
		.result       (result),
		.result_stall (result_stall)
	);

endmodule
